>>> hdl/can_signal_unpack_scale_macros.svh
// Assertion macros for the CAN signal unpack and scale block.
`ifndef CAN_SIGNAL_UNPACK_SCALE_MACROS_SVH
`define CAN_SIGNAL_UNPACK_SCALE_MACROS_SVH

`ifndef ASSERT_OFF

// Condition that must hold at every clock edge outside reset.
`define CSUS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CSUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CSUS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define CSUS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/csus_pkg.sv
// Package: widths, status codes and helpers for the CAN signal unpack and scale block.
`timescale 1ns / 1ps

package csus_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned START_W   = 6;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned OFS_W     = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned SCALED_W  = 59;
  // field value plus offset, signed: covers unsigned 32-bit plus offset
  localparam int unsigned VAL_W     = WORD_W + 2;
  localparam int unsigned PROD_W    = VAL_W + GAIN_W;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_LENGTH = 2'd1,
    STATUS_BAD_START  = 2'd2
  } status_t;

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
    swap_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

>>> hdl/csus_in_if.sv
// Input channel: payload words and signal descriptor with valid/ready.
`timescale 1ns / 1ps

interface csus_in_if import csus_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [WORD_W-1:0]          data_low;
  logic [WORD_W-1:0]          data_high;
  logic [START_W-1:0]         start_bit;
  logic signed [LEN_W-1:0]    length;
  logic signed [GAIN_W-1:0]   gain;
  logic signed [OFS_W-1:0]    add_offset;

  modport source (
    output valid, data_low, data_high, start_bit, length, gain, add_offset,
    input  ready
  );
  modport sink (
    input  valid, data_low, data_high, start_bit, length, gain, add_offset,
    output ready
  );
endinterface

>>> hdl/csus_out_if.sv
// Result channel: extracted field, scaled value and status with valid/ready.
`timescale 1ns / 1ps

interface csus_out_if import csus_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [WORD_W-1:0]           raw_bits;
  logic signed [SCALED_W-1:0]  scaled_value;
  logic [STATUS_W-1:0]         status;

  modport source (
    output valid, raw_bits, scaled_value, status,
    input  ready
  );
  modport sink (
    input  valid, raw_bits, scaled_value, status,
    output ready
  );
endinterface

>>> hdl/can_signal_unpack_scale.sv
// Top level: CAN signal extraction, sign extension, offset and fixed-point gain.
`timescale 1ns / 1ps
`include "can_signal_unpack_scale_macros.svh"

// Decodes one CAN signal per cycle while the result side is not stalled. Each
// transaction carries the 64-bit payload and a descriptor (start bit, signed
// length where negative means big-endian, offset, gain with 16 fraction bits).
// Two pipeline stages: the field is extracted and offset on the way into the
// first register, the 34x24 signed multiply fills the result register, and one
// transaction is accepted in every cycle that the result side is not stalled.
// Bad descriptors return status 1 (length zero or above 32) or 2 (field runs
// off the payload) with zero raw and scaled values. cfg_wdata sets signed mode
// (sign-extend fields longer than one bit); write it only while the pipeline
// is empty.

module can_signal_unpack_scale import csus_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  csus_in_if.sink     in_ch,
  csus_out_if.source  out_ch
);

  logic signed_mode_r;

  // stage 1 registers
  logic                      s1_valid_r;
  logic [WORD_W-1:0]         s1_raw_r;
  logic signed [VAL_W-1:0]   s1_val_r;
  logic signed [GAIN_W-1:0]  s1_gain_r;
  status_t                   s1_status_r;

  // result registers
  logic                        out_valid_r;
  logic [WORD_W-1:0]           out_raw_r;
  logic signed [SCALED_W-1:0]  out_scaled_r;
  status_t                     out_status_r;

  logic out_adv;
  logic s1_adv;

  // extraction
  logic              neg;
  logic [LEN_W-1:0]  n;
  logic [7:0]        start8;
  logic [7:0]        n8;
  logic              bad_len;
  logic              bad_start;
  logic [5:0]        sh;
  logic [4:0]        pos;
  logic [4:0]        pos_eff;
  logic [2*WORD_W-1:0] pair;
  logic [WORD_W-1:0] word;
  logic [5:0]        mask_sh;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] raw_ex;
  logic [4:0]        n_m1;
  logic              sgn;
  logic [WORD_W:0]   ext;
  logic signed [VAL_W-1:0] val_ex;

  logic [WORD_W-1:0]         s1_raw_nxt;
  logic signed [VAL_W-1:0]   s1_val_nxt;
  status_t                   s1_status_nxt;

  logic signed [PROD_W-1:0]    prod;
  logic signed [SCALED_W-1:0]  out_scaled_nxt;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_adv      = !s1_valid_r || out_adv;
  assign in_ch.ready = s1_adv;

  always_comb begin
    neg    = in_ch.length[LEN_W-1];
    n      = neg ? LEN_W'(-in_ch.length) : LEN_W'(in_ch.length);
    start8 = {2'b00, in_ch.start_bit};
    n8     = {1'b0, n};

    bad_len   = (n == '0) || (n > 7'd32);
    bad_start = neg ? (n8 > start8 + 8'd1) : (start8 + n8 > 8'd64);

    // pick the 32-bit window of the payload and the field position in it
    if (neg) begin
      if (in_ch.start_bit < 6'd32) begin
        sh  = 6'd0;
        pos = in_ch.start_bit[4:0];
      end else if (start8 > n8 + 8'd31) begin
        sh  = 6'd32;
        pos = in_ch.start_bit[4:0];
      end else begin
        // field crosses the word boundary
        sh  = 6'(start8 - n8 + 8'd1);
        pos = 5'(n - 7'd1);
      end
    end else begin
      if (in_ch.start_bit > 6'd31) begin
        sh  = 6'd32;
        pos = in_ch.start_bit[4:0];
      end else if (start8 + n8 <= 8'd32) begin
        sh  = 6'd0;
        pos = in_ch.start_bit[4:0];
      end else begin
        sh  = in_ch.start_bit;
        pos = 5'd0;
      end
    end

    pair    = {in_ch.data_high, in_ch.data_low} >> sh;
    word    = neg ? swap_bytes(pair[WORD_W-1:0]) : pair[WORD_W-1:0];
    pos_eff = neg ? (5'd31 - pos) : pos;

    mask_sh = 6'd32 - n[5:0];
    mask    = {WORD_W{1'b1}} >> mask_sh[4:0];
    raw_ex  = (word >> pos_eff) & mask;

    n_m1 = n[4:0] - 5'd1;
    sgn  = raw_ex[n_m1];
    if (signed_mode_r && (n > 7'd1) && sgn) begin
      ext = {1'b1, raw_ex | ~mask};
    end else begin
      ext = {1'b0, raw_ex};
    end
    val_ex = $signed({ext[WORD_W], ext})
           + $signed({{(VAL_W-OFS_W){in_ch.add_offset[OFS_W-1]}}, in_ch.add_offset});

    if (bad_len) begin
      s1_status_nxt = STATUS_BAD_LENGTH;
      s1_raw_nxt    = '0;
      s1_val_nxt    = '0;
    end else if (bad_start) begin
      s1_status_nxt = STATUS_BAD_START;
      s1_raw_nxt    = '0;
      s1_val_nxt    = '0;
    end else begin
      s1_status_nxt = STATUS_OK;
      s1_raw_nxt    = raw_ex;
      s1_val_nxt    = val_ex;
    end
  end

  always_comb begin
    prod           = s1_val_r * s1_gain_r;
    out_scaled_nxt = {prod[PROD_W-1], prod};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
    end else if (cfg_we) begin
      signed_mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_raw_r    <= s1_raw_nxt;
      s1_val_r    <= s1_val_nxt;
      s1_gain_r   <= in_ch.gain;
      s1_status_r <= s1_status_nxt;
    end
    if (out_adv) begin
      out_raw_r    <= s1_raw_r;
      out_scaled_r <= out_scaled_nxt;
      out_status_r <= s1_status_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.raw_bits     = out_raw_r;
  assign out_ch.scaled_value = out_scaled_r;
  assign out_ch.status       = out_status_r;

  // rejected descriptors never carry data
  `CSUS_ASSERT_ALWAYS(a_bad_is_zero, clk, rst_n, !out_valid_r || out_status_r == STATUS_OK || (out_raw_r == '0 && out_scaled_r == '0))

  // a staged transaction moves into the result register when it is free
  `CSUS_ASSERT_NEXT(a_s1_to_out, clk, rst_n, s1_valid_r && out_adv, out_valid_r)

  // zero length is always flagged as a length error
  `CSUS_ASSERT_NEXT(a_zero_len, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.length == '0, s1_status_r == STATUS_BAD_LENGTH)

endmodule
